// ----- rtl/core/ngr_pkg.sv -----
// Shared types and constants for the non-uniform three-point gradient block.
// Used by the front end, the job queue, the back end and the top level.
package ngr_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;
  // sample difference width and job operand width
  localparam int DIFF_W      = DATA_WIDTH + 1;
  localparam int JOB_W       = DATA_WIDTH + 2;
  // hs*hd*(hs+hd) and the numerator sum both fit here
  localparam int MAG_W       = 3 * DIFF_W + 1;
  localparam int PROD_W      = DIFF_W + JOB_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_SINGLE = 2'd2,
    ST_SAT    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    JOB_DIV,     // a / b directly
    JOB_POLY,    // full non-uniform formula: hs=a, hd=b, yc-yb=c, yb-ya=d
    JOB_ZERO,    // zero spacing
    JOB_SINGLE   // one-sample run
  } job_kind_t;

  typedef struct packed {
    job_kind_t               kind;
    logic                    fin;
    logic signed [JOB_W-1:0] a;
    logic signed [JOB_W-1:0] b;
    logic signed [JOB_W-1:0] c;
    logic signed [JOB_W-1:0] d;
  } job_t;

endpackage

// ----- rtl/core/ngr_front.sv -----
// Front end: accepts samples, keeps the two previous samples and turns each
// item into zero, one or two jobs. Depends on ngr_pkg.
module ngr_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic signed [ngr_pkg::DATA_WIDTH-1:0]  x_coord,
  input  logic signed [ngr_pkg::DATA_WIDTH-1:0]  y_value,
  input  logic                                   run_end,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  output logic                                   job_valid,
  output ngr_pkg::job_t                          job,
  input  logic                                   job_ready
);

  logic signed [ngr_pkg::DATA_WIDTH-1:0] px0, py0, py1;
  logic signed [ngr_pkg::DIFF_W-1:0]     spacing;
  logic [1:0]                            seen;
  ngr_pkg::job_t                         held0, held1;
  logic [1:0]                            held_cnt;

  logic                                  accept;
  logic signed [ngr_pkg::DIFF_W-1:0]     h, dy;
  logic signed [ngr_pkg::JOB_W-1:0]      hsum;
  ngr_pkg::job_t                         side_job, inner_job, single_job, fin_job;

  assign sample_stall = (held_cnt != 2'd0);
  assign accept       = sample_valid && !sample_stall;
  assign job_valid    = (held_cnt != 2'd0);
  assign job          = held0;

  always_comb begin
    h    = ngr_pkg::DIFF_W'(x_coord) - ngr_pkg::DIFF_W'(px0);
    dy   = ngr_pkg::DIFF_W'(y_value) - ngr_pkg::DIFF_W'(py0);
    hsum = ngr_pkg::JOB_W'(spacing) + ngr_pkg::JOB_W'(h);

    side_job   = '0;
    side_job.a = ngr_pkg::JOB_W'(dy);
    side_job.b = ngr_pkg::JOB_W'(h);
    side_job.kind = (h == '0) ? ngr_pkg::JOB_ZERO : ngr_pkg::JOB_DIV;

    fin_job     = side_job;
    fin_job.fin = 1'b1;

    single_job      = '0;
    single_job.kind = ngr_pkg::JOB_SINGLE;
    single_job.fin  = 1'b1;

    inner_job = '0;
    if (spacing == '0 || h == '0 || hsum == '0) begin
      inner_job.kind = ngr_pkg::JOB_ZERO;
    end else if (spacing == h) begin
      // equal spacings: central difference
      inner_job.kind = ngr_pkg::JOB_DIV;
      inner_job.a    = ngr_pkg::JOB_W'(y_value) - ngr_pkg::JOB_W'(py1);
      inner_job.b    = ngr_pkg::JOB_W'(spacing) + ngr_pkg::JOB_W'(spacing);
    end else begin
      inner_job.kind = ngr_pkg::JOB_POLY;
      inner_job.a    = ngr_pkg::JOB_W'(spacing);
      inner_job.b    = ngr_pkg::JOB_W'(h);
      inner_job.c    = ngr_pkg::JOB_W'(dy);
      inner_job.d    = ngr_pkg::JOB_W'(py0) - ngr_pkg::JOB_W'(py1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= 2'd0;
      held_cnt <= 2'd0;
    end else if (accept) begin
      px0 <= x_coord;
      py0 <= y_value;
      if (seen == 2'd0) begin
        if (run_end) begin
          held0    <= single_job;
          held_cnt <= 2'd1;
        end else begin
          seen <= 2'd1;
        end
      end else begin
        held0     <= (seen == 2'd1) ? side_job : inner_job;
        held1     <= fin_job;
        held_cnt  <= run_end ? 2'd2 : 2'd1;
        py1       <= py0;
        spacing   <= h;
        seen      <= run_end ? 2'd0 : 2'd2;
      end
    end else if (held_cnt != 2'd0 && job_ready) begin
      held0    <= held1;
      held_cnt <= held_cnt - 2'd1;
    end
  end

endmodule

// ----- rtl/core/ngr_queue.sv -----
// Short job queue between the front end and the back end.
// Depends on ngr_pkg for the job type and depth.
module ngr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ngr_pkg::job_t push_job,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output ngr_pkg::job_t pop_job
);

  ngr_pkg::job_t                 slots [ngr_pkg::QUEUE_DEPTH];
  logic [ngr_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [ngr_pkg::QPTR_W:0]      count;
  logic                          do_push, do_pop;

  assign push_ready = (count != (ngr_pkg::QPTR_W+1)'(ngr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_job;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/ngr_back.sv -----
// Back end: runs one job at a time on a shared 33x34 multiplier and a
// radix-2 restoring divider, then holds the result in the output register.
// Depends on ngr_pkg.
module ngr_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  job_valid,
  input  ngr_pkg::job_t                         job,
  output logic                                  job_pop,
  output logic signed [ngr_pkg::DATA_WIDTH-1:0] slope,
  output logic                                  final_point,
  output logic [1:0]                            status,
  output logic                                  slope_valid,
  input  logic                                  slope_stall
);

  localparam int QW  = ngr_pkg::DATA_WIDTH;
  localparam int DW  = ngr_pkg::DIFF_W;
  localparam int JW  = ngr_pkg::JOB_W;
  localparam int MW  = ngr_pkg::MAG_W;
  localparam int PW  = ngr_pkg::PROD_W;
  localparam int CW  = $clog2(QW);
  localparam int XW  = MW + QW;

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_COMB, B_CHECK, B_DIV, B_RES, B_DONE} bstate_t;

  bstate_t               state;
  logic                  fin, neg, c_neg, d_neg, den_neg;
  logic [DW-1:0]         hsm, hdm, dcm, dam;
  logic [JW-1:0]         sm;
  logic [2*DW-1:0]       p1, p2, d1;
  logic [PW-1:0]         prod;
  logic [MW-1:0]         n1, n2, num_mag, den_mag, rem;
  logic [QW-1:0]         low, quo;
  logic [3:0]            step;
  logic [CW-1:0]         cnt;
  logic [QW-1:0]         res_slope;
  ngr_pkg::status_t      res_status;

  logic [DW-1:0]         ma;
  logic [JW-1:0]         mb;
  logic signed [MW:0]    n1s, n2s, numv;
  logic [XW-1:0]         shifted, den_top;
  logic [MW:0]           rem_sh;
  logic                  qbit;
  logic [QW:0]           lim;
  logic signed [JW-1:0]  ab_sum;
  logic                  out_load;

  function automatic logic [JW-1:0] mag(input logic signed [JW-1:0] v);
    mag = v[JW-1] ? JW'(-v) : JW'(v);
  endfunction

  assign job_pop  = (state == B_IDLE) && job_valid;
  assign ab_sum   = job.a + job.b;
  assign out_load = (state == B_DONE) && (!slope_valid || !slope_stall);

  always_comb begin
    ma = hsm;
    mb = JW'(hsm);
    case (step)
      4'd0: begin ma = hsm;            mb = JW'(hsm); end
      4'd1: begin ma = hdm;            mb = JW'(hdm); end
      4'd2: begin ma = hsm;            mb = JW'(hdm); end
      4'd3: begin ma = p1[DW-1:0];     mb = JW'(dcm); end
      4'd4: begin ma = p1[2*DW-1:DW];  mb = JW'(dcm); end
      4'd5: begin ma = p2[DW-1:0];     mb = JW'(dam); end
      4'd6: begin ma = p2[2*DW-1:DW];  mb = JW'(dam); end
      4'd7: begin ma = d1[DW-1:0];     mb = sm;       end
      4'd8: begin ma = d1[2*DW-1:DW];  mb = sm;       end
      default: begin ma = hsm;         mb = JW'(hsm); end
    endcase

    n1s  = c_neg ? -$signed({1'b0, n1}) : $signed({1'b0, n1});
    n2s  = d_neg ? -$signed({1'b0, n2}) : $signed({1'b0, n2});
    numv = n1s + n2s;

    shifted = XW'(num_mag) << ngr_pkg::FRAC_BITS;
    den_top = XW'(den_mag) << QW;

    rem_sh = {rem, low[QW-1]};
    qbit   = (rem_sh >= {1'b0, den_mag});

    lim = neg ? ((QW+1)'(1) << (QW-1)) : (((QW+1)'(1) << (QW-1)) - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      slope_valid <= 1'b0;
    end else begin
      if (out_load) slope_valid <= 1'b1;
      else if (slope_valid && !slope_stall) slope_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            fin <= job.fin;
            case (job.kind)
              ngr_pkg::JOB_DIV: begin
                num_mag <= MW'(mag(job.a));
                den_mag <= MW'(mag(job.b));
                neg     <= job.a[JW-1] ^ job.b[JW-1];
                state   <= B_CHECK;
              end
              ngr_pkg::JOB_POLY: begin
                hsm     <= DW'(mag(job.a));
                hdm     <= DW'(mag(job.b));
                dcm     <= DW'(mag(job.c));
                dam     <= DW'(mag(job.d));
                sm      <= mag(ab_sum);
                c_neg   <= job.c[JW-1];
                d_neg   <= job.d[JW-1];
                den_neg <= job.a[JW-1] ^ job.b[JW-1] ^ ab_sum[JW-1];
                step    <= 4'd0;
                state   <= B_MUL;
              end
              ngr_pkg::JOB_ZERO: begin
                res_slope  <= '0;
                res_status <= ngr_pkg::ST_ZERO;
                state      <= B_DONE;
              end
              default: begin
                res_slope  <= '0;
                res_status <= ngr_pkg::ST_SINGLE;
                state      <= B_DONE;
              end
            endcase
          end
        end
        B_MUL: begin
          // multiply at step k, consume the product at step k+1
          prod <= ma * mb;
          step <= step + 4'd1;
          case (step)
            4'd1: p1  <= prod[2*DW-1:0];
            4'd2: p2  <= prod[2*DW-1:0];
            4'd3: d1  <= prod[2*DW-1:0];
            4'd4: n1  <= MW'(prod);
            4'd5: n1  <= n1 + (MW'(prod) << DW);
            4'd6: n2  <= MW'(prod);
            4'd7: n2  <= n2 + (MW'(prod) << DW);
            4'd8: den_mag <= MW'(prod);
            4'd9: begin
              den_mag <= den_mag + (MW'(prod) << DW);
              state   <= B_COMB;
            end
            default: ;
          endcase
        end
        B_COMB: begin
          neg     <= numv[MW] ^ den_neg;
          num_mag <= numv[MW] ? MW'(-numv) : MW'(numv);
          state   <= B_CHECK;
        end
        B_CHECK: begin
          if (shifted >= den_top) begin
            // quotient needs more than QW bits
            res_slope  <= neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
            res_status <= ngr_pkg::ST_SAT;
            state      <= B_DONE;
          end else begin
            rem   <= shifted[XW-1:QW];
            low   <= shifted[QW-1:0];
            quo   <= '0;
            cnt   <= '0;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          rem <= qbit ? MW'(rem_sh - {1'b0, den_mag}) : MW'(rem_sh);
          low <= low << 1;
          quo <= {quo[QW-2:0], qbit};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(QW-1)) state <= B_RES;
        end
        B_RES: begin
          if ({1'b0, quo} > lim) begin
            res_slope  <= neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
            res_status <= ngr_pkg::ST_SAT;
          end else begin
            res_slope  <= neg ? QW'(-quo) : quo;
            res_status <= ngr_pkg::ST_OK;
          end
          state <= B_DONE;
        end
        B_DONE: begin
          if (out_load) begin
            slope       <= res_slope;
            status      <= res_status;
            final_point <= fin;
            state       <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/nonuniform_gradient_3point_unit.sv -----
// Streaming dy/dx over a run of (x, y) Q16.16 samples, one sample per item.
// The front end takes a sample and queues one job per derivative (two on the
// item that ends a run of two or more samples); while it hands those jobs to
// the queue it holds off the next sample. The back end runs one job at a time:
// a one-sided or central difference takes 32 steps of the radix-2 divider plus
// setup and result; a point with unequal spacings first forms its products on
// the single 33x34 multiplier and combines the wide numerator and denominator.
// The divider sets the rate; the four-entry job queue and the output register
// let either side stall alone.
// Depends on ngr_pkg, ngr_front, ngr_queue and ngr_back.
module nonuniform_gradient_3point_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [ngr_pkg::DATA_WIDTH-1:0] x_coord,
  input  logic signed [ngr_pkg::DATA_WIDTH-1:0] y_value,
  input  logic                                  run_end,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  output logic signed [ngr_pkg::DATA_WIDTH-1:0] slope,
  output logic                                  final_point,
  output logic [1:0]                            status,
  output logic                                  slope_valid,
  input  logic                                  slope_stall
);

  logic          fj_valid, fj_ready, bj_valid, bj_pop;
  ngr_pkg::job_t fj, bj;

  ngr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .x_coord      (x_coord),
    .y_value      (y_value),
    .run_end      (run_end),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .job_valid    (fj_valid),
    .job          (fj),
    .job_ready    (fj_ready)
  );

  ngr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fj_valid),
    .push_job   (fj),
    .push_ready (fj_ready),
    .pop        (bj_pop),
    .pop_valid  (bj_valid),
    .pop_job    (bj)
  );

  ngr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (bj_valid),
    .job         (bj),
    .job_pop     (bj_pop),
    .slope       (slope),
    .final_point (final_point),
    .status      (status),
    .slope_valid (slope_valid),
    .slope_stall (slope_stall)
  );

endmodule
